// ===== design/crs_pkg.sv =====
// Shared constants for the Catmull-Rom point and slope evaluator.
// No dependencies; compiled first.
package crs_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int T_WIDTH_DEF     = 16;

   // register stages from transfer in to result register
   localparam int PIPE_DEPTH = 8;

endpackage : crs_pkg

// ===== design/crs_req_if.sv =====
// Request channel: four 2-D control points and the segment parameter.
// Depends on crs_pkg for default widths.
interface crs_req_if #(
   parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH_DEF,
   parameter int T_WIDTH     = crs_pkg::T_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] p0_x;
   logic signed [COORD_WIDTH-1:0] p0_y;
   logic signed [COORD_WIDTH-1:0] p1_x;
   logic signed [COORD_WIDTH-1:0] p1_y;
   logic signed [COORD_WIDTH-1:0] p2_x;
   logic signed [COORD_WIDTH-1:0] p2_y;
   logic signed [COORD_WIDTH-1:0] p3_x;
   logic signed [COORD_WIDTH-1:0] p3_y;
   logic        [T_WIDTH-1:0]     frac_t;

   modport source (
      output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, frac_t,
      input  ready
   );

   modport sink (
      input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, frac_t,
      output ready
   );
endinterface : crs_req_if

// ===== design/crs_rsp_if.sv =====
// Response channel: interpolated point and its derivative along t.
// Depends on crs_pkg for default widths.
interface crs_rsp_if #(
   parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] slope_x;
   logic signed [COORD_WIDTH-1:0] slope_y;

   modport source (
      output valid, pos_x, pos_y, slope_x, slope_y,
      input  ready
   );

   modport sink (
      input  valid, pos_x, pos_y, slope_x, slope_y,
      output ready
   );
endinterface : crs_rsp_if

// ===== design/crs_round_sat.sv =====
// Round-to-nearest (ties away from zero) by a constant power of two, then
// saturate to a signed output width. Combinational; no dependencies.
module crs_round_sat #(
   parameter int IN_W  = 40,
   parameter int SHIFT = 17,
   parameter int OUT_W = 16
) (
   input  logic signed [IN_W-1:0]  value,
   output logic signed [OUT_W-1:0] result
);
   localparam int SW = IN_W + 1;
   localparam int QW = SW - SHIFT;

   logic signed [SW-1:0]     biased;
   logic signed [QW-1:0]     quo;
   logic        [QW-OUT_W:0] top_bits;

   // negative values take half minus one so the floor shift rounds ties away
   assign biased   = SW'(value) + (SW'(1) <<< (SHIFT - 1)) - SW'({1'b0, value[IN_W-1]});
   assign quo      = QW'(biased >>> SHIFT);
   assign top_bits = quo[QW-1:OUT_W-1];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         result = quo[OUT_W-1:0];
      end else if (quo[QW-1]) begin
         result = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(OUT_W-1){1'b1}}};
      end
   end
endmodule : crs_round_sat

// ===== design/crs_axis.sv =====
// One coordinate axis of the evaluator: polynomial coefficients, Horner
// multiply/add stages, rounding. Depends on crs_pkg and crs_round_sat.
module crs_axis #(
   parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH_DEF,
   parameter int T_WIDTH     = crs_pkg::T_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic [crs_pkg::PIPE_DEPTH-1:0] stage_en,
   input  logic signed [COORD_WIDTH-1:0] p0,
   input  logic signed [COORD_WIDTH-1:0] p1,
   input  logic signed [COORD_WIDTH-1:0] p2,
   input  logic signed [COORD_WIDTH-1:0] p3,
   input  logic        [T_WIDTH-1:0]     frac_t,
   output logic signed [COORD_WIDTH-1:0] pos,
   output logic signed [COORD_WIDTH-1:0] slope
);
   import crs_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int T    = T_WIDTH;
   localparam int ABW  = W + 1;           // a = 2*p1, b = p2 - p0
   localparam int CW   = W + 4;           // c and d
   localparam int H1W  = W + T + 5;       // d*t + c*2^T
   localparam int S1W  = W + T + 6;       // 3*d*t + 2*c*2^T
   localparam int MH4W = H1W + T + 1;
   localparam int H2W  = W + 2 * T + 5;
   localparam int S2W  = W + 2 * T + 7;
   localparam int LOW  = H2W / 2;
   localparam int HIW  = H2W - LOW;
   localparam int LOPW = LOW + T;
   localparam int HIPW = HIW + T + 1;
   localparam int H3W  = W + 3 * T + 6;

   logic signed [CW-1:0] e0, e1, e2, e3;

   logic signed [ABW-1:0] a1_ff, a1_in, b1_ff, b1_in;
   logic signed [CW-1:0]  c1_ff, c1_in, d1_ff, d1_in;
   logic        [T-1:0]   t1_ff;

   logic signed [H1W-1:0] m2_ff, m2_in;
   logic signed [ABW-1:0] a2_ff, b2_ff;
   logic signed [CW-1:0]  c2_ff;
   logic        [T-1:0]   t2_ff;

   logic signed [H1W-1:0] h3_ff, h3_in;
   logic signed [S1W-1:0] s3_ff, s3_in;
   logic signed [ABW-1:0] a3_ff, b3_ff;
   logic        [T-1:0]   t3_ff;

   logic signed [MH4W-1:0] mh4_ff, mh4_in;
   logic signed [S2W-1:0]  ms4_ff, ms4_in;
   logic signed [ABW-1:0]  a4_ff, b4_ff;
   logic        [T-1:0]    t4_ff;

   logic signed [H2W-1:0] h5_ff, h5_in;
   logic signed [S2W-1:0] sa5_ff, sa5_in;
   logic signed [ABW-1:0] a5_ff;
   logic        [T-1:0]   t5_ff;

   logic        [LOPW-1:0] lo6_ff, lo6_in;
   logic signed [HIPW-1:0] hi6_ff, hi6_in;
   logic signed [W-1:0]    sl6_ff, sl6_in;
   logic signed [ABW-1:0]  a6_ff;

   logic signed [H3W-1:0] h7_ff, h7_in;
   logic signed [W-1:0]   sl7_ff;

   logic signed [W-1:0] pos8_ff, pos8_in, sl8_ff;

   assign e0 = CW'(p0);
   assign e1 = CW'(p1);
   assign e2 = CW'(p2);
   assign e3 = CW'(p3);

   always_comb begin
      a1_in = ABW'(p1) <<< 1;
      b1_in = ABW'(p2) - ABW'(p0);
      c1_in = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
      d1_in = e1 + (e1 <<< 1) - e2 - (e2 <<< 1) + e3 - e0;

      m2_in = H1W'(d1_ff) * H1W'($signed({1'b0, t1_ff}));

      h3_in = m2_ff + (H1W'(c2_ff) <<< T);
      s3_in = (S1W'(m2_ff) <<< 1) + S1W'(m2_ff) + (S1W'(c2_ff) <<< (T + 1));

      mh4_in = MH4W'(h3_ff) * MH4W'($signed({1'b0, t3_ff}));
      ms4_in = S2W'(s3_ff) * S2W'($signed({1'b0, t3_ff}));

      h5_in  = H2W'(mh4_ff + (MH4W'(b4_ff) <<< (2 * T)));
      sa5_in = ms4_ff + (S2W'(b4_ff) <<< (2 * T));

      // last Horner product split in two halves to keep multipliers narrow
      lo6_in = LOPW'(h5_ff[LOW-1:0]) * LOPW'(t5_ff);
      hi6_in = HIPW'($signed(h5_ff[H2W-1:LOW])) * HIPW'($signed({1'b0, t5_ff}));

      h7_in = (H3W'(hi6_ff) <<< LOW) + H3W'(lo6_ff) + (H3W'(a6_ff) <<< (3 * T));
   end

   crs_round_sat #(
      .IN_W  (S2W),
      .SHIFT (2 * T + 1),
      .OUT_W (W)
   ) u_round_slope (
      .value  (sa5_ff),
      .result (sl6_in)
   );

   crs_round_sat #(
      .IN_W  (H3W),
      .SHIFT (3 * T + 1),
      .OUT_W (W)
   ) u_round_pos (
      .value  (h7_ff),
      .result (pos8_in)
   );

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         a1_ff <= a1_in;
         b1_ff <= b1_in;
         c1_ff <= c1_in;
         d1_ff <= d1_in;
         t1_ff <= frac_t;
      end
      if (stage_en[1]) begin
         m2_ff <= m2_in;
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
         c2_ff <= c1_ff;
         t2_ff <= t1_ff;
      end
      if (stage_en[2]) begin
         h3_ff <= h3_in;
         s3_ff <= s3_in;
         a3_ff <= a2_ff;
         b3_ff <= b2_ff;
         t3_ff <= t2_ff;
      end
      if (stage_en[3]) begin
         mh4_ff <= mh4_in;
         ms4_ff <= ms4_in;
         a4_ff  <= a3_ff;
         b4_ff  <= b3_ff;
         t4_ff  <= t3_ff;
      end
      if (stage_en[4]) begin
         h5_ff  <= h5_in;
         sa5_ff <= sa5_in;
         a5_ff  <= a4_ff;
         t5_ff  <= t4_ff;
      end
      if (stage_en[5]) begin
         lo6_ff <= lo6_in;
         hi6_ff <= hi6_in;
         sl6_ff <= sl6_in;
         a6_ff  <= a5_ff;
      end
      if (stage_en[6]) begin
         h7_ff  <= h7_in;
         sl7_ff <= sl6_ff;
      end
      if (stage_en[7]) begin
         pos8_ff <= pos8_in;
         sl8_ff  <= sl7_ff;
      end
   end

   assign pos   = pos8_ff;
   assign slope = sl8_ff;
endmodule : crs_axis

// ===== design/catmull_rom_point_and_slope.sv =====
// Catmull-Rom point and slope evaluator, top level.
// Depends on crs_pkg, crs_req_if, crs_rsp_if and crs_axis.
//
// Takes one request per clock unless the pipeline is stalled, and returns
// the point on the segment between p1 and p2 and its derivative along t,
// each rounded to nearest (ties away from zero) and saturated to the
// coordinate range. The pipeline holds the three Horner multiply stages,
// each followed by an add stage, plus coefficient setup and the final
// rounding register. Every stage carries its own valid bit and holds only
// while the stage after it is full and stalled, so bubbles close up and the
// request side takes items while a result waits, until every stage is full.
module catmull_rom_point_and_slope #(
   parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH_DEF,
   parameter int T_WIDTH     = crs_pkg::T_WIDTH_DEF
) (
   input logic      clock,
   input logic      reset,
   crs_req_if.sink  req_ch,
   crs_rsp_if.source rsp_ch
);
   import crs_pkg::*;

   logic [PIPE_DEPTH-1:0] valid_ff, valid_in, stage_en;

   always_comb begin
      stage_en[PIPE_DEPTH-1] = !valid_ff[PIPE_DEPTH-1] || rsp_ch.ready;
      for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = stage_en[0] ? req_ch.valid : valid_ff[0];
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ch.ready = stage_en[0];
   assign rsp_ch.valid = valid_ff[PIPE_DEPTH-1];

   crs_axis #(
      .COORD_WIDTH (COORD_WIDTH),
      .T_WIDTH     (T_WIDTH)
   ) u_axis_x (
      .clock    (clock),
      .stage_en (stage_en),
      .p0       (req_ch.p0_x),
      .p1       (req_ch.p1_x),
      .p2       (req_ch.p2_x),
      .p3       (req_ch.p3_x),
      .frac_t   (req_ch.frac_t),
      .pos      (rsp_ch.pos_x),
      .slope    (rsp_ch.slope_x)
   );

   crs_axis #(
      .COORD_WIDTH (COORD_WIDTH),
      .T_WIDTH     (T_WIDTH)
   ) u_axis_y (
      .clock    (clock),
      .stage_en (stage_en),
      .p0       (req_ch.p0_y),
      .p1       (req_ch.p1_y),
      .p2       (req_ch.p2_y),
      .p3       (req_ch.p3_y),
      .frac_t   (req_ch.frac_t),
      .pos      (rsp_ch.pos_y),
      .slope    (rsp_ch.slope_y)
   );
endmodule : catmull_rom_point_and_slope
